[rtl/ldmf_pkg.sv]
// Package for the length-prefixed deframer with station address filter.
// Holds widths, register indexes, parse phase and status codes, result type.
// No dependencies.
package ldmf_pkg;

  // Ports that exist on the register map, and ports that are wired up
  localparam int unsigned RegPorts  = 4;
  localparam int unsigned NumPorts  = 4;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned AddrW     = 48;
  localparam int unsigned LenW      = 16;
  localparam int unsigned MaskW     = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;

  // Smallest frame that carries a full Ethernet header
  localparam logic [LenW-1:0] MinFrame   = 16'd14;
  localparam logic [LenW-1:0] MaxLenRst  = 16'd1518;
  // Header is four bytes; the address occupies the first six payload bytes
  localparam logic [1:0]      HdrLastIdx = 2'd3;
  localparam logic [2:0]      AddrBytes  = 3'd6;
  // Group (multicast) flag: low bit of the first address byte
  localparam int unsigned     GroupBit   = 40;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPort0  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPort1  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPort2  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPort3  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEnable = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxLen = 3'd5;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhSkip    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    StNone     = 2'd0,
    StComplete = 2'd1,
    StOversize = 2'd2,
    StRunt     = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             payload_valid;
    logic             frame_first;
    logic             frame_last;
    logic [MaskW-1:0] deliver_mask;
    status_e          status;
  } result_t;

endpackage

[rtl/ldmf_if.sv]
// Channel interfaces of the deframer: byte input, result output, config writes.
// Depends on ldmf_pkg.
interface ldmf_in_if import ldmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ldmf_out_if import ldmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             payload_valid;
  logic             frame_first;
  logic             frame_last;
  logic [MaskW-1:0] deliver_mask;
  logic [1:0]       status;

  modport source (output valid, output out_byte, output payload_valid,
                  output frame_first, output frame_last, output deliver_mask,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input payload_valid,
                  input frame_first, input frame_last, input deliver_mask,
                  input status, output ready);
endinterface

interface ldmf_cfg_if import ldmf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/length_prefixed_deframer_mac_filter.sv]
// Top level of the length-prefixed deframer with station address filter.
// Depends on ldmf_pkg and the channel interfaces in ldmf_if.sv.
//
// Usage:
//   in_i   carries the stream one byte per transfer: a 4-byte little-endian
//          length, then that many frame bytes. Every accepted byte gives
//          exactly one result on out_o.
//   out_o  carries the result: the byte echoed with first/last marks for
//          good frames, the delivery mask on the last byte, and a status code
//          (frame complete, oversize header dropped, runt dropped).
//   cfg_i  writes the four port addresses, the port enable bits and the
//          maximum frame length; it is always ready. Write only while idle.
// Throughput is one byte per cycle while in_i.ready is high; the per-byte
// work is a counter update and a 48-bit address compare per port, between
// the parser state and the result register.
// A two-entry output (result register plus skid register) lets the input
// take one more byte while a result waits; with both full, in_i.ready drops.
// Reset puts the parser in header phase, clears the addresses and the enable
// bits and sets the maximum frame length to 1518.
module length_prefixed_deframer_mac_filter
  import ldmf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ldmf_in_if.sink    in_i,
  ldmf_out_if.source out_o,
  ldmf_cfg_if.sink   cfg_i
);

  // Configuration registers
  logic [AddrW-1:0] port_addr_q [RegPorts];
  logic [MaskW-1:0] port_en_q;
  logic [LenW-1:0]  max_len_q;

  // Parser state
  phase_e           phase_q, phase_d;
  logic [1:0]       hdr_idx_q, hdr_idx_d;
  logic [23:0]      len_acc_q, len_acc_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [2:0]       pos_q, pos_d;      // saturates at the address length
  logic [AddrW-1:0] dest_q, dest_d;

  // Output register and skid register
  result_t          out_q, skid_q, res;
  logic             out_valid_q, skid_valid_q;

  logic             in_fire, out_pop, cfg_fire;
  logic [31:0]      len_full;
  logic [MaskW-1:0] mask;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_pop  = out_valid_q && out_o.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = !skid_valid_q;
  assign cfg_i.ready = 1'b1;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegPorts; i++) port_addr_q[i] <= '0;
      port_en_q <= '0;
      max_len_q <= MaxLenRst;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        RegPort0:  port_addr_q[0] <= cfg_i.data;
        RegPort1:  port_addr_q[1] <= cfg_i.data;
        RegPort2:  port_addr_q[2] <= cfg_i.data;
        RegPort3:  port_addr_q[3] <= cfg_i.data;
        RegEnable: port_en_q      <= cfg_i.data[MaskW-1:0];
        RegMaxLen: max_len_q      <= cfg_i.data[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Delivery mask: all enabled ports for group addresses, else matching ones.
  // The last byte of a frame is at least byte 14, so dest_q is complete there.
  always_comb begin
    mask = '0;
    for (int i = 0; i < RegPorts; i++) begin
      if (i < NumPorts && port_en_q[i] &&
          (dest_q[GroupBit] || dest_q == port_addr_q[i])) begin
        mask[i] = 1'b1;
      end
    end
  end

  // Full length as seen on the fourth header byte
  assign len_full = {in_i.rx_byte, len_acc_q};

  // Next parser state
  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    len_acc_d = len_acc_q;
    left_d    = left_q;
    pos_d     = pos_q;
    dest_d    = dest_q;
    case (phase_q)
      PhPayload: begin
        if (pos_q < AddrBytes) begin
          dest_d = {dest_q[AddrW-ByteW-1:0], in_i.rx_byte};
          pos_d  = pos_q + 3'd1;
        end
        if (left_q <= 16'd1) begin
          left_d  = '0;
          phase_d = PhHeader;
        end else begin
          left_d = left_q - 16'd1;
        end
      end
      PhSkip: begin
        if (left_q <= 16'd1) begin
          left_d  = '0;
          phase_d = PhHeader;
        end else begin
          left_d = left_q - 16'd1;
        end
      end
      default: begin
        // Header phase; the unused code behaves the same
        phase_d   = PhHeader;
        hdr_idx_d = hdr_idx_q + 2'd1;
        case (hdr_idx_q)
          2'd0:    len_acc_d[7:0]   = in_i.rx_byte;
          2'd1:    len_acc_d[15:8]  = in_i.rx_byte;
          2'd2:    len_acc_d[23:16] = in_i.rx_byte;
          default: len_acc_d        = '0;
        endcase
        if (hdr_idx_q == HdrLastIdx) begin
          len_acc_d = '0;
          if (len_full > {16'd0, max_len_q}) begin
            phase_d = PhHeader;
          end else if (len_full[LenW-1:0] < MinFrame) begin
            if (len_full[LenW-1:0] != '0) begin
              left_d  = len_full[LenW-1:0];
              phase_d = PhSkip;
            end
          end else begin
            left_d  = len_full[LenW-1:0];
            pos_d   = '0;
            dest_d  = '0;
            phase_d = PhPayload;
          end
        end
      end
    endcase
  end

  // Result of the current byte
  always_comb begin
    res = '{out_byte: '0, payload_valid: 1'b0, frame_first: 1'b0,
            frame_last: 1'b0, deliver_mask: '0, status: StNone};
    case (phase_q)
      PhPayload: begin
        res.out_byte      = in_i.rx_byte;
        res.payload_valid = 1'b1;
        res.frame_first   = (pos_q == 3'd0);
        if (left_q <= 16'd1) begin
          res.frame_last   = 1'b1;
          res.deliver_mask = mask;
          res.status       = StComplete;
        end
      end
      PhSkip: begin
        if (left_q <= 16'd1) res.status = StRunt;
      end
      default: begin
        if (hdr_idx_q == HdrLastIdx) begin
          if (len_full > {16'd0, max_len_q}) begin
            res.status = StOversize;
          end else if (len_full[LenW-1:0] == '0) begin
            res.status = StRunt;
          end
        end
      end
    endcase
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      hdr_idx_q <= '0;
      len_acc_q <= '0;
      left_q    <= '0;
      pos_q     <= '0;
      dest_q    <= '0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      len_acc_q <= len_acc_d;
      left_q    <= left_d;
      pos_q     <= pos_d;
      dest_q    <= dest_d;
    end
  end

  // Output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      if (out_valid_q && !out_pop) skid_valid_q <= 1'b1;
      out_valid_q <= 1'b1;
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) out_q <= skid_q;
    end else if (in_fire) begin
      if (!out_valid_q || out_pop) out_q  <= res;
      else                         skid_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_q.out_byte;
  assign out_o.payload_valid = out_q.payload_valid;
  assign out_o.frame_first   = out_q.frame_first;
  assign out_o.frame_last    = out_q.frame_last;
  assign out_o.deliver_mask  = out_q.deliver_mask;
  assign out_o.status        = out_q.status;

  // Skid entry is only ever filled behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds data without a waiting result");

  // End of a payload run returns the parser to header phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PhPayload && left_q <= 16'd1) |=> phase_q == PhHeader)
    else $error("parser did not return to header after last byte");

  // Last mark only with frame-complete status and payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_last) |->
      (out_q.status == StComplete && out_q.payload_valid))
    else $error("last mark without completed frame");

  // Delivery mask only on the last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.frame_last) |-> out_q.deliver_mask == '0)
    else $error("delivery mask outside the last byte");

endmodule
